/* design/label_region_statistics_macros.svh */
// Assertion macros for the label region statistics block.
// Included by the RTL files that carry concurrent checks; needs no other file.
`ifndef LABEL_REGION_STATISTICS_MACROS_SVH
`define LABEL_REGION_STATISTICS_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LRS_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lrs: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define LRS_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lrs: next-cycle check failed");

`endif

/* design/lrs_pkg.sv */
// Package for the label region statistics block: sizes, table entry type,
// empty-entry value and the saturating counter step. No dependencies.
`default_nettype none

package lrs_pkg;

   localparam int unsigned LABEL_COUNT = 255;
   localparam int unsigned LABEL_BITS  = 8;
   localparam int unsigned POS_BITS    = 10;
   localparam int unsigned COUNT_BITS  = 31;
   localparam int unsigned ADDR_BITS   = (LABEL_COUNT > 1) ? $clog2(LABEL_COUNT) : 1;

   localparam logic [POS_BITS-1:0]   POS_ALL_ONES = '1;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX    = '1;
   localparam logic [COUNT_BITS-1:0] COUNT_ONE    = COUNT_BITS'(1);

   localparam logic REQ_VOXEL = 1'b0;
   localparam logic REQ_READ  = 1'b1;

   typedef struct packed {
      logic [COUNT_BITS-1:0] volume;
      logic [COUNT_BITS-1:0] surface;
      logic [POS_BITS-1:0]   min_x;
      logic [POS_BITS-1:0]   max_x;
      logic [POS_BITS-1:0]   min_y;
      logic [POS_BITS-1:0]   max_y;
      logic [POS_BITS-1:0]   min_z;
      logic [POS_BITS-1:0]   max_z;
   } stats_type;

   localparam stats_type EMPTY_STATS = '{
      volume:  COUNT_ONE,
      surface: COUNT_ONE,
      min_x:   POS_ALL_ONES,
      max_x:   '0,
      min_y:   POS_ALL_ONES,
      max_y:   '0,
      min_z:   POS_ALL_ONES,
      max_z:   '0
   };

   // count + 1, held at all ones
   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
      sat_inc = (c == COUNT_MAX) ? COUNT_MAX : c + COUNT_ONE;
   endfunction

endpackage

`default_nettype wire

/* design/label_region_statistics.sv */
// Label region statistics: per-label volume, surface and bounding box table.
// Depends on lrs_pkg and label_region_statistics_macros.svh.
`default_nettype none

// A word is taken when start is high and busy is low. The accept edge issues
// the registered read of the label's table entry, and the following cycle
// (busy high) updates the entry and writes it back, so the next word's read
// always sees the new contents. One result word follows on the rsp_ ports for
// one cycle with rsp_valid high, in the same cycle in which the next word can
// be taken; the receiver cannot stall it, so it must take every word. No new
// word is taken while busy is high, as the single-port read-modify-write of the
// table must finish first. Voxel words (req_type 0) return out_voxel = label
// on a surface voxel, else 0, with counts and box fields 0. Read words
// (req_type 1) return the label's counts and box and put the entry back to
// empty (counts 1, minima all ones, maxima 0). Labels 0 and above the table
// size never touch it; a read of one returns the empty values. Entries start
// empty right after reset through per-entry valid bits, so no clearing pass
// is needed.
module label_region_statistics (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output      logic                               busy,
   input  wire logic                               req_type,
   input  wire logic [lrs_pkg::LABEL_BITS-1:0]     req_label,
   input  wire logic [lrs_pkg::POS_BITS-1:0]       req_pos_x,
   input  wire logic [lrs_pkg::POS_BITS-1:0]       req_pos_y,
   input  wire logic [lrs_pkg::POS_BITS-1:0]       req_pos_z,
   input  wire logic [lrs_pkg::LABEL_BITS-1:0]     req_nb_x_plus,
   input  wire logic [lrs_pkg::LABEL_BITS-1:0]     req_nb_x_minus,
   input  wire logic [lrs_pkg::LABEL_BITS-1:0]     req_nb_y_plus,
   input  wire logic [lrs_pkg::LABEL_BITS-1:0]     req_nb_y_minus,
   input  wire logic [lrs_pkg::LABEL_BITS-1:0]     req_nb_z_plus,
   input  wire logic [lrs_pkg::LABEL_BITS-1:0]     req_nb_z_minus,
   output      logic                               rsp_valid,
   output      logic [lrs_pkg::LABEL_BITS-1:0]     rsp_out_voxel,
   output      logic [lrs_pkg::COUNT_BITS-1:0]     rsp_volume_count,
   output      logic [lrs_pkg::COUNT_BITS-1:0]     rsp_surface_count,
   output      logic [lrs_pkg::POS_BITS-1:0]       rsp_box_min_x,
   output      logic [lrs_pkg::POS_BITS-1:0]       rsp_box_max_x,
   output      logic [lrs_pkg::POS_BITS-1:0]       rsp_box_min_y,
   output      logic [lrs_pkg::POS_BITS-1:0]       rsp_box_max_y,
   output      logic [lrs_pkg::POS_BITS-1:0]       rsp_box_min_z,
   output      logic [lrs_pkg::POS_BITS-1:0]       rsp_box_max_z
);
   import lrs_pkg::*;

`include "label_region_statistics_macros.svh"

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   // control
   state_type              state_ff;
   logic                   rsp_valid_ff;

   // word held for the update cycle
   logic                   type_ff;
   logic [LABEL_BITS-1:0]  label_ff;
   logic [POS_BITS-1:0]    pos_x_ff;
   logic [POS_BITS-1:0]    pos_y_ff;
   logic [POS_BITS-1:0]    pos_z_ff;
   logic                   surf_ff;
   logic                   in_table_ff;
   logic                   hit_ff;
   logic [ADDR_BITS-1:0]   addr_ff;

   // table and its valid bits
   stats_type              stats_mem [LABEL_COUNT];
   stats_type              rd_data_ff;
   logic [LABEL_COUNT-1:0] valid_ff;

   // result word
   logic [LABEL_BITS-1:0]  out_voxel_ff;
   stats_type              rsp_stats_ff;

   // next values
   logic                   accept;
   logic                   surf_in;
   logic                   in_table_in;
   logic [ADDR_BITS-1:0]   addr_in;
   stats_type              base;
   stats_type              upd;
   logic                   wr_en;
   logic [LABEL_BITS-1:0]  out_voxel_in;
   stats_type              rsp_stats_in;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff == ST_EXEC);

   // surface: any face neighbour with another label
   assign surf_in = (req_nb_x_plus  != req_label) || (req_nb_x_minus != req_label) ||
                    (req_nb_y_plus  != req_label) || (req_nb_y_minus != req_label) ||
                    (req_nb_z_plus  != req_label) || (req_nb_z_minus != req_label);

   assign in_table_in = (req_label != '0) && (32'(req_label) <= LABEL_COUNT);
   assign addr_in     = in_table_in ? ADDR_BITS'(req_label - LABEL_BITS'(1)) : '0;

   // update cycle: entries whose valid bit is clear read as empty
   always_comb begin
      base = hit_ff ? rd_data_ff : EMPTY_STATS;
      upd  = base;
      upd.volume = sat_inc(base.volume);
      if (surf_ff) begin
         upd.surface = sat_inc(base.surface);
      end
      if (pos_x_ff < base.min_x) upd.min_x = pos_x_ff;
      if (pos_x_ff > base.max_x) upd.max_x = pos_x_ff;
      if (pos_y_ff < base.min_y) upd.min_y = pos_y_ff;
      if (pos_y_ff > base.max_y) upd.max_y = pos_y_ff;
      if (pos_z_ff < base.min_z) upd.min_z = pos_z_ff;
      if (pos_z_ff > base.max_z) upd.max_z = pos_z_ff;

      wr_en = busy && (type_ff == REQ_VOXEL) && in_table_ff;

      if (type_ff == REQ_READ) begin
         out_voxel_in = '0;
         rsp_stats_in = base;
      end else begin
         out_voxel_in = surf_ff ? label_ff : '0;
         rsp_stats_in = '0;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               rsp_valid_ff <= 1'b0;
               if (accept) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            default: begin
               rsp_valid_ff <= 1'b0;
               state_ff     <= ST_IDLE;
            end
         endcase
      end
      if (accept) begin
         type_ff     <= req_type;
         label_ff    <= req_label;
         pos_x_ff    <= req_pos_x;
         pos_y_ff    <= req_pos_y;
         pos_z_ff    <= req_pos_z;
         surf_ff     <= surf_in;
         in_table_ff <= in_table_in;
         addr_ff     <= addr_in;
      end
      if (busy) begin
         out_voxel_ff <= out_voxel_in;
         rsp_stats_ff <= rsp_stats_in;
      end
   end

   // valid bits: set on update, cleared by a read
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         if (accept) begin
            hit_ff <= in_table_in && valid_ff[addr_in];
         end
         if (busy && in_table_ff) begin
            valid_ff[addr_ff] <= (type_ff == REQ_VOXEL);
         end
      end
   end

   // single-port table, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stats_mem[addr_ff] <= upd;
      end
      if (accept) begin
         rd_data_ff <= stats_mem[addr_in];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_voxel     = out_voxel_ff;
   assign rsp_volume_count  = rsp_stats_ff.volume;
   assign rsp_surface_count = rsp_stats_ff.surface;
   assign rsp_box_min_x     = rsp_stats_ff.min_x;
   assign rsp_box_max_x     = rsp_stats_ff.max_x;
   assign rsp_box_min_y     = rsp_stats_ff.min_y;
   assign rsp_box_max_y     = rsp_stats_ff.max_y;
   assign rsp_box_min_z     = rsp_stats_ff.min_z;
   assign rsp_box_max_z     = rsp_stats_ff.max_z;

   `LRS_ASSERT_NXT(a_accept_busy, clock, reset, accept, busy)
   `LRS_ASSERT_NXT(a_exec_result, clock, reset, busy, rsp_valid_ff && !busy)
   `LRS_ASSERT_IMP(a_voxel_zero_counts, clock, reset,
      rsp_valid_ff && (rsp_stats_ff.volume == '0), rsp_stats_ff.surface == '0)
   `LRS_ASSERT_IMP(a_surface_le_volume, clock, reset,
      rsp_valid_ff && (rsp_stats_ff.volume != '0),
      (rsp_stats_ff.surface <= rsp_stats_ff.volume) && (out_voxel_ff == '0))

endmodule

`default_nettype wire
